// ----- sv/thermistor_to_celsius_smoother_core_assert.svh -----
// Assertion macros for the thermistor smoother core.
`ifndef THERMISTOR_TO_CELSIUS_SMOOTHER_CORE_ASSERT_SVH
`define THERMISTOR_TO_CELSIUS_SMOOTHER_CORE_ASSERT_SVH

// plain clocked property, off during reset
`define TTCS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// signal holds in the cycle after cond
`define TTCS_ASSERT_HOLD(lbl, clk, rst_n, cond, sig, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
		else $error(msg);

`endif

// ----- sv/ttcs_pkg.sv -----
// Package: microcode types, program ROM and thermistor threshold tables.
package ttcs_pkg;

	localparam int ROM_SIZE = 150;
	localparam int IDX_W = 8;
	localparam int SAMPLE_W = 16;
	localparam int TEMP_W = 8;
	localparam int WEIGHT_W = 9;
	localparam int ACC_W = 17;
	localparam logic [WEIGHT_W-1:0] WEIGHT_FULL = 9'd256;
	localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 9'd64;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MUL_NEW,
		ST_MUL_OLD,
		ST_FINISH
	} step_t;

	typedef enum logic [2:0] {
		OP_LOAD,
		OP_SCAN,
		OP_MUL_NEW,
		OP_MUL_OLD,
		OP_FINISH
	} op_t;

	typedef enum logic [2:0] {
		C_IN_VALID,
		C_SCAN_DONE,
		C_HIT,
		C_ALWAYS,
		C_OUT_FREE
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t tgt_t;
		step_t tgt_f;
	} ctrl_t;

	function automatic ctrl_t ucode(input step_t s);
		ctrl_t c;
		unique case (s)
			ST_IDLE:    c = '{op: OP_LOAD,    cond: C_IN_VALID,  tgt_t: ST_SCAN,    tgt_f: ST_IDLE};
			ST_SCAN:    c = '{op: OP_SCAN,    cond: C_SCAN_DONE, tgt_t: ST_MUL_NEW, tgt_f: ST_SCAN};
			ST_MUL_NEW: c = '{op: OP_MUL_NEW, cond: C_HIT,       tgt_t: ST_MUL_OLD, tgt_f: ST_FINISH};
			ST_MUL_OLD: c = '{op: OP_MUL_OLD, cond: C_ALWAYS,    tgt_t: ST_FINISH,  tgt_f: ST_FINISH};
			ST_FINISH:  c = '{op: OP_FINISH,  cond: C_OUT_FREE,  tgt_t: ST_IDLE,    tgt_f: ST_FINISH};
			default:    c = '{op: OP_LOAD,    cond: C_ALWAYS,    tgt_t: ST_IDLE,    tgt_f: ST_IDLE};
		endcase
		return c;
	endfunction

	localparam logic [SAMPLE_W-1:0] MOTOR_ROM [ROM_SIZE] = '{
		16'd48716, 16'd47863, 16'd47253, 16'd46635, 16'd46009, 16'd45376, 16'd44736, 16'd44090,
		16'd43439, 16'd42783, 16'd42122, 16'd41458, 16'd40791, 16'd40121, 16'd39450, 16'd38777,
		16'd38104, 16'd37431, 16'd36759, 16'd36087, 16'd35418, 16'd34750, 16'd34086, 16'd33425,
		16'd32768, 16'd32115, 16'd31467, 16'd30825, 16'd30188, 16'd29558, 16'd28933, 16'd28316,
		16'd27706, 16'd27104, 16'd26509, 16'd25922, 16'd25344, 16'd24774, 16'd24213, 16'd23660,
		16'd23117, 16'd22583, 16'd22058, 16'd21543, 16'd21036, 16'd20540, 16'd20052, 16'd19575,
		16'd19106, 16'd18648, 16'd18199, 16'd17759, 16'd17328, 16'd16907, 16'd16495, 16'd16092,
		16'd15699, 16'd15314, 16'd14938, 16'd14571, 16'd14213, 16'd13863, 16'd13521, 16'd13188,
		16'd12863, 16'd12545, 16'd12236, 16'd11934, 16'd11640, 16'd11353, 16'd11073, 16'd10801,
		16'd10535, 16'd10276, 16'd10024, 16'd9778,  16'd9539,  16'd9306,  16'd9079,  16'd8858,
		16'd8642,  16'd8433,  16'd8228,  16'd8030,  16'd7836,  16'd7647,  16'd7464,  16'd7285,
		16'd7111,  16'd6941,  16'd6776,  16'd6616,  16'd6459,  16'd6307,  16'd6159,  16'd6015,
		16'd5874,  16'd5737,  16'd5604,  16'd5474,  16'd5348,  16'd5225,  16'd5105,  16'd4988,
		16'd4875,  16'd4764,  16'd4656,  16'd4551,  16'd4449,  16'd4350,  16'd4253,  16'd4158,
		16'd4066,  16'd3976,  16'd3889,  16'd3804,  16'd3721,  16'd3640,  16'd3561,  16'd3484,
		16'd3410,  16'd3337,  16'd3265,  16'd3196,  16'd3128,  16'd3063,  16'd2998,  16'd2936,
		16'd2874,  16'd2815,  16'd2757,  16'd2700,  16'd2645,  16'd2591,  16'd2538,  16'd2486,
		16'd2436,  16'd2387,  16'd2340,  16'd2293,  16'd2248,  16'd2203,  16'd2160,  16'd2117,
		16'd2076,  16'd2036,  16'd1996,  16'd1958,  16'd1920,  16'd1883
	};

	localparam logic [SAMPLE_W-1:0] SWITCH_ROM [ROM_SIZE] = '{
		16'd53022, 16'd52352, 16'd51870, 16'd51377, 16'd50876, 16'd50367, 16'd49848, 16'd49322,
		16'd48787, 16'd48245, 16'd47696, 16'd47140, 16'd46578, 16'd46009, 16'd45435, 16'd44856,
		16'd44272, 16'd43683, 16'd43091, 16'd42495, 16'd41896, 16'd41295, 16'd40691, 16'd40086,
		16'd39480, 16'd38872, 16'd38265, 16'd37658, 16'd37051, 16'd36446, 16'd35841, 16'd35239,
		16'd34639, 16'd34042, 16'd33448, 16'd32857, 16'd32270, 16'd31686, 16'd31108, 16'd30534,
		16'd29965, 16'd29401, 16'd28843, 16'd28291, 16'd27745, 16'd27205, 16'd26671, 16'd26144,
		16'd25624, 16'd25111, 16'd24605, 16'd24106, 16'd23614, 16'd23130, 16'd22653, 16'd22184,
		16'd21723, 16'd21269, 16'd20822, 16'd20384, 16'd19953, 16'd19529, 16'd19114, 16'd18706,
		16'd18306, 16'd17913, 16'd17528, 16'd17151, 16'd16780, 16'd16418, 16'd16062, 16'd15714,
		16'd15373, 16'd15039, 16'd14712, 16'd14392, 16'd14079, 16'd13773, 16'd13473, 16'd13180,
		16'd12893, 16'd12612, 16'd12338, 16'd12070, 16'd11807, 16'd11551, 16'd11300, 16'd11055,
		16'd10816, 16'd10582, 16'd10354, 16'd10130, 16'd9912,  16'd9699,  16'd9491,  16'd9288,
		16'd9089,  16'd8895,  16'd8705,  16'd8520,  16'd8340,  16'd8163,  16'd7991,  16'd7822,
		16'd7658,  16'd7497,  16'd7340,  16'd7187,  16'd7038,  16'd6892,  16'd6749,  16'd6610,
		16'd6474,  16'd6341,  16'd6211,  16'd6084,  16'd5961,  16'd5840,  16'd5722,  16'd5606,
		16'd5494,  16'd5384,  16'd5276,  16'd5171,  16'd5069,  16'd4969,  16'd4871,  16'd4775,
		16'd4682,  16'd4590,  16'd4501,  16'd4414,  16'd4329,  16'd4246,  16'd4164,  16'd4085,
		16'd4007,  16'd3931,  16'd3857,  16'd3784,  16'd3713,  16'd3644,  16'd3576,  16'd3510,
		16'd3445,  16'd3382,  16'd3319,  16'd3259,  16'd3200,  16'd3141
	};

endpackage

// ----- sv/thermistor_to_celsius_smoother_core.sv -----
// Thermistor-to-Celsius converter with per-channel low-pass, microcoded sequencer.
// Sequence per word: accept, table scan, multiply-new, multiply-old (on a hit only), finish, out_valid
// (up to N = min(TABLE_ENTRIES,150) entries scanned); the table scan compares one ROM entry per cycle.
// A new word is accepted only once the last one has left finish; a finished word may wait in the
// output register while the next word is accepted.
// Reset (arst_n low, async): sequencer to idle, filters to 0, weight to 64, no output.
module thermistor_to_celsius_smoother_core #(
	parameter int TABLE_ENTRIES = 150
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [8:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        sensor_channel,
	input  logic [15:0] adc_sample,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        channel_echo,
	output logic [7:0]  raw_celsius,
	output logic [7:0]  smoothed_celsius,
	output logic        out_of_range
);

	localparam int SCAN_LEN = (TABLE_ENTRIES < ttcs_pkg::ROM_SIZE) ?
		TABLE_ENTRIES : ttcs_pkg::ROM_SIZE;
	localparam logic [ttcs_pkg::IDX_W-1:0] SCAN_LAST = ttcs_pkg::IDX_W'(SCAN_LEN - 1);

	ttcs_pkg::step_t step_q, step_d;
	ttcs_pkg::ctrl_t uc;

	logic [ttcs_pkg::WEIGHT_W-1:0] weight_q;
	logic [ttcs_pkg::WEIGHT_W-1:0] w_sat;
	logic [ttcs_pkg::WEIGHT_W-1:0] w_old;
	logic [ttcs_pkg::SAMPLE_W-1:0] sample_q;
	logic                          chan_q;
	logic [ttcs_pkg::IDX_W-1:0]    idx_q;
	logic                          hit_q;
	logic [ttcs_pkg::ACC_W-1:0]    acc_q;
	logic [ttcs_pkg::TEMP_W-1:0]   filt_q [2];
	logic [ttcs_pkg::TEMP_W-1:0]   prev;
	logic [ttcs_pkg::SAMPLE_W-1:0] thr;
	logic                          hit_now;
	logic                          out_free;
	logic                          cond_ok;
	logic                          out_valid_q;

	assign uc = ttcs_pkg::ucode(step_q);
	assign thr = chan_q ? ttcs_pkg::SWITCH_ROM[idx_q] : ttcs_pkg::MOTOR_ROM[idx_q];
	assign hit_now = sample_q > thr;
	assign out_free = !out_valid_q || out_ready;
	assign w_sat = (weight_q > ttcs_pkg::WEIGHT_FULL) ? ttcs_pkg::WEIGHT_FULL : weight_q;
	assign w_old = ttcs_pkg::WEIGHT_FULL - w_sat;
	assign prev = filt_q[chan_q];

	always_comb begin
		case (uc.cond)
			ttcs_pkg::C_IN_VALID:  cond_ok = in_valid;
			ttcs_pkg::C_SCAN_DONE: cond_ok = hit_now || (idx_q == SCAN_LAST);
			ttcs_pkg::C_HIT:       cond_ok = hit_q;
			ttcs_pkg::C_OUT_FREE:  cond_ok = out_free;
			default:               cond_ok = 1'b1;
		endcase
		step_d = cond_ok ? uc.tgt_t : uc.tgt_f;
		in_ready = (uc.op == ttcs_pkg::OP_LOAD);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ttcs_pkg::ST_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= ttcs_pkg::WEIGHT_RESET;
		end else if (cfg_we) begin
			weight_q <= cfg_wdata;
		end
	end

	// datapath driven by the current control word
	always_ff @(posedge clk) begin
		case (uc.op)
			ttcs_pkg::OP_LOAD: begin
				sample_q <= adc_sample;
				chan_q   <= sensor_channel;
				idx_q    <= '0;
			end
			ttcs_pkg::OP_SCAN: begin
				if (!hit_now) begin
					idx_q <= idx_q + 1'b1;
				end
			end
			ttcs_pkg::OP_MUL_NEW: acc_q <= ttcs_pkg::ACC_W'(idx_q) * ttcs_pkg::ACC_W'(w_sat);
			ttcs_pkg::OP_MUL_OLD:
				acc_q <= acc_q + ttcs_pkg::ACC_W'(prev) * ttcs_pkg::ACC_W'(w_old);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (uc.op == ttcs_pkg::OP_LOAD) begin
			hit_q <= 1'b0;
		end else if (uc.op == ttcs_pkg::OP_SCAN && hit_now) begin
			hit_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_q[0] <= '0;
			filt_q[1] <= '0;
		end else if (uc.op == ttcs_pkg::OP_FINISH && out_free && hit_q) begin
			filt_q[chan_q] <= acc_q[15:8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (uc.op == ttcs_pkg::OP_FINISH && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (uc.op == ttcs_pkg::OP_FINISH && out_free) begin
			channel_echo     <= chan_q;
			raw_celsius      <= hit_q ? idx_q : '0;
			smoothed_celsius <= hit_q ? acc_q[15:8] : prev;
			out_of_range     <= !hit_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- sv/ttcs_checker.sv -----
// Port-level checker for the thermistor smoother core, with its bind.
`include "thermistor_to_celsius_smoother_core_assert.svh"

module ttcs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] raw_celsius,
	input logic       out_of_range
);

	`TTCS_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid, "word dropped")
	`TTCS_ASSERT_HOLD(a_raw_hold, clk, arst_n, out_valid && !out_ready, raw_celsius, "raw moved")
	`TTCS_ASSERT(a_oor_zero, clk, arst_n, out_valid && out_of_range |-> raw_celsius == 8'd0, "oor raw")
	`TTCS_ASSERT(a_raw_rng, clk, arst_n, out_valid |-> raw_celsius < 8'd150, "raw range")
	`TTCS_ASSERT(a_busy, clk, arst_n, in_valid && in_ready |=> !in_ready, "ready while busy")

endmodule

bind thermistor_to_celsius_smoother_core ttcs_checker u_ttcs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.raw_celsius  (raw_celsius),
	.out_of_range (out_of_range)
);

// ----- dv/thermistor_to_celsius_smoother_core_tb.sv -----
// Self-checking testbench for the thermistor smoother core: table/filter predictor, random stalls.
module thermistor_to_celsius_smoother_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_LEN = 150;
	localparam int SCAN_LEN = (TABLE_LEN < ttcs_pkg::ROM_SIZE) ? TABLE_LEN : ttcs_pkg::ROM_SIZE;
	localparam int LAT_CYCLES = SCAN_LEN + 8;
	localparam int unsigned CYCLE_LIMIT = 2000000;
	localparam int HOLD_CYCLES = 2000;
	localparam int RANDOM_WORDS = 1900;
	localparam int PHASES = 3;
	localparam int BATCHES = 3;
	localparam int MAX_PRINTS = 40;
	localparam logic CH_MOTOR = 1'b0;
	localparam logic CH_SWITCH = 1'b1;

	typedef struct packed {
		logic       ch;
		logic [7:0] raw;
		logic [7:0] smooth;
		logic       oor;
	} reading_t;

	class reading_scoreboard;
		logic [ttcs_pkg::WEIGHT_W-1:0] weight;
		logic [ttcs_pkg::TEMP_W-1:0]   filt [2];
		reading_t                      due_q [$];
		int unsigned                   errors;

		function new();
			weight = ttcs_pkg::WEIGHT_RESET;
			filt[0] = '0;
			filt[1] = '0;
			errors = 0;
		endfunction

		static function logic [ttcs_pkg::SAMPLE_W-1:0] threshold(logic ch, int i);
			return ch ? ttcs_pkg::SWITCH_ROM[i] : ttcs_pkg::MOTOR_ROM[i];
		endfunction

		// table search plus low-pass update for one accepted word
		function void note_sample(logic ch, logic [ttcs_pkg::SAMPLE_W-1:0] s);
			reading_t r;
			int deg;
			int w;
			int acc;
			deg = -1;
			for (int i = 0; i < SCAN_LEN; i++) begin
				if (s > threshold(ch, i)) begin
					deg = i;
					break;
				end
			end
			if (deg >= 0) begin
				w = (weight > ttcs_pkg::WEIGHT_FULL) ?
					int'(ttcs_pkg::WEIGHT_FULL) : int'(weight);
				acc = deg * w + int'(filt[ch]) * (int'(ttcs_pkg::WEIGHT_FULL) - w);
				filt[ch] = 8'(acc >> 8);
			end
			r.ch = ch;
			r.raw = (deg < 0) ? 8'd0 : 8'(deg);
			r.smooth = filt[ch];
			r.oor = (deg < 0);
			due_q.push_back(r);
		endfunction

		task report(string msg);
			if (errors < MAX_PRINTS)
				$display("%0t ERROR %s", $time, msg);
			errors++;
		endtask

		task check_reading(reading_t got);
			reading_t want;
			if (due_q.size() == 0) begin
				report($sformatf("unexpected word ch=%0d raw=%0d smooth=%0d oor=%0d",
					got.ch, got.raw, got.smooth, got.oor));
				return;
			end
			want = due_q.pop_front();
			if (got.ch !== want.ch)
				report($sformatf("channel_echo got %0d want %0d", got.ch, want.ch));
			if (got.raw !== want.raw)
				report($sformatf("raw_celsius got %0d want %0d (ch %0d)", got.raw, want.raw, want.ch));
			if (got.smooth !== want.smooth)
				report($sformatf("smoothed_celsius got %0d want %0d (ch %0d)",
					got.smooth, want.smooth, want.ch));
			if (got.oor !== want.oor)
				report($sformatf("out_of_range got %0d want %0d (ch %0d)", got.oor, want.oor, want.ch));
		endtask

		function int pending();
			return due_q.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [8:0]  cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        sensor_channel = 1'b0;
	logic [15:0] adc_sample = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        channel_echo;
	logic [7:0]  raw_celsius;
	logic [7:0]  smoothed_celsius;
	logic        out_of_range;

	logic        rx_hold = 1'b0;
	int          tx_idle_pct = 0;
	int          rx_idle_pct = 0;
	int          drift_idx [2] = '{40, 60};
	int unsigned cycle_count = 0;
	event        pressure_go;

	reading_scoreboard sb = new();

	thermistor_to_celsius_smoother_core #(
		.TABLE_ENTRIES(TABLE_LEN)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sensor_channel(sensor_channel),
		.adc_sample(adc_sample),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.channel_echo(channel_echo),
		.raw_celsius(raw_celsius),
		.smoothed_celsius(smoothed_celsius),
		.out_of_range(out_of_range)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_sample(sensor_channel, adc_sample);
			if (out_valid && out_ready)
				sb.check_reading(reading_t'({channel_echo, raw_celsius, smoothed_celsius,
					out_of_range}));
		end
	end

	// long receiver stall so the core fills and backs up its input
	initial begin
		@(pressure_go);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	task send_word(input logic ch, input logic [15:0] s);
		if ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < tx_idle_pct) @(posedge clk);
		end
		in_valid <= 1'b1;
		sensor_channel <= ch;
		adc_sample <= s;
		do @(posedge clk); while (!in_ready);
	endtask

	task finish_batch();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task set_weight(input logic [8:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.weight = v;
	endtask

	function automatic logic [15:0] pick_sample(logic ch);
		int r;
		int i;
		int step;
		int lo;
		int hi;
		r = $urandom_range(99);
		if (r < 50) begin
			step = $urandom_range(6);
			drift_idx[ch] = drift_idx[ch] + step - 3;
			if (drift_idx[ch] < 0)
				drift_idx[ch] = 0;
			if (drift_idx[ch] > SCAN_LEN - 1)
				drift_idx[ch] = SCAN_LEN - 1;
			i = drift_idx[ch];
		end else if (r < 70) begin
			i = $urandom_range(SCAN_LEN - 1);
		end else if (r < 80) begin
			return 16'($urandom_range(int'(reading_scoreboard::threshold(ch, SCAN_LEN - 1))));
		end else if (r < 88) begin
			return reading_scoreboard::threshold(ch, $urandom_range(SCAN_LEN - 1));
		end else begin
			return 16'($urandom);
		end
		lo = int'(reading_scoreboard::threshold(ch, i)) + 1;
		hi = (i == 0) ? 65535 : int'(reading_scoreboard::threshold(ch, i - 1));
		return 16'($urandom_range(hi, lo));
	endfunction

	function automatic logic [8:0] pick_weight();
		case ($urandom_range(6))
			0: return 9'd0;
			1: return 9'd1;
			2: return 9'd256;
			3: return 9'd257;
			4: return 9'd511;
			default: return 9'($urandom_range(511));
		endcase
	endfunction

	initial begin
		logic ch;
		tx_idle_pct = 13;
		rx_idle_pct = 45;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset weight, table ends and misses on both channels, then edge weight settings
		send_word(CH_MOTOR, 16'd65535);
		send_word(CH_MOTOR, 16'd48717);
		send_word(CH_MOTOR, 16'd48716);
		send_word(CH_MOTOR, 16'd1884);
		send_word(CH_MOTOR, 16'd1883);
		send_word(CH_MOTOR, 16'd0);
		send_word(CH_MOTOR, 16'd32768);
		send_word(CH_MOTOR, 16'd25000);
		send_word(CH_SWITCH, 16'd65535);
		send_word(CH_SWITCH, 16'd53023);
		send_word(CH_SWITCH, 16'd53022);
		send_word(CH_SWITCH, 16'd3142);
		send_word(CH_SWITCH, 16'd3141);
		send_word(CH_SWITCH, 16'd0);
		send_word(CH_SWITCH, 16'd40000);
		finish_batch();
		set_weight(9'd256);
		send_word(CH_MOTOR, 16'd10000);
		send_word(CH_SWITCH, 16'd2000);
		finish_batch();
		set_weight(9'd511);
		send_word(CH_MOTOR, 16'd1884);
		send_word(CH_SWITCH, 16'd3142);
		finish_batch();
		set_weight(9'd0);
		send_word(CH_MOTOR, 16'd50000);
		send_word(CH_SWITCH, 16'd20000);
		finish_batch();
		set_weight(9'd257);
		send_word(CH_MOTOR, 16'd60000);
		finish_batch();
		set_weight(9'd1);
		send_word(CH_SWITCH, 16'd60000);

		for (int p = 0; p < PHASES; p++) begin
			tx_idle_pct = (p == 0) ? 13 : (p == 1) ? 45 : 0;
			rx_idle_pct = (p == 0) ? 45 : (p == 1) ? 13 : 0;
			for (int b = 0; b < BATCHES; b++) begin
				finish_batch();
				set_weight(pick_weight());
				for (int k = 0; k < RANDOM_WORDS / (PHASES * BATCHES); k++) begin
					if (p == PHASES - 1 && b == 1 && k == 20)
						-> pressure_go;
					ch = 1'($urandom_range(1));
					send_word(ch, pick_sample(ch));
				end
			end
		end

		finish_batch();
		repeat (LAT_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
